>>> rtl/core/seht_pkg.sv
`default_nettype none

package seht_pkg;

    // Field and register widths
    localparam int COORD_BITS    = 24;
    localparam int FRAC_BITS     = 4;
    localparam int INSET_BITS    = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;

    // Datapath widths, sized from the worst-case magnitudes of each term
    localparam int GEO_W = 28;    // X, Y, P, Q, shrunk width and height
    localparam int SQ_W  = 52;    // W^2, H^2
    localparam int T_W   = 56;    // scratch product of two coordinates
    localparam int A_W   = 103;   // A
    localparam int B_W   = 106;   // B / 2
    localparam int C_W   = 108;   // C
    localparam int D_W   = 212;   // (B^2 - 4AC) / 4

    // Shared multiplier: MUL_W x MUL_W, DIG_W multiplier bits per step
    localparam int MUL_W     = 112;
    localparam int DIG_W     = 8;
    localparam int DIG_LOG   = 3;
    localparam int MUL_STEPS = MUL_W / DIG_W;
    localparam int STEP_W    = 4;
    localparam int PROD_W    = 2 * MUL_W;

    localparam logic [STEP_W-1:0] STEPS_GEO  = 4'd4;   // coordinate-sized operand
    localparam logic [STEP_W-1:0] STEPS_SQ   = 4'd7;   // squared-coordinate operand
    localparam logic [STEP_W-1:0] STEPS_WIDE = 4'd13;  // quadratic coefficient operand

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [1:0] EDGE_LAST = 2'd3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BOX_LEFT   = 3'd0,
        CFG_BOX_TOP    = 3'd1,
        CFG_BOX_WIDTH  = 3'd2,
        CFG_BOX_HEIGHT = 3'd3,
        CFG_INSET      = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] left;
        logic signed [COORD_BITS-1:0] top;
        logic        [COORD_BITS-1:0] width;
        logic        [COORD_BITS-1:0] height;
        logic        [INSET_BITS-1:0] inset;
    } t_cfg;

    typedef enum logic [1:0] {
        KIND_SEG,
        KIND_RECT,
        KIND_MISS
    } t_kind;

    typedef struct packed {
        t_kind                        kind;
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
    } t_job;

    typedef enum logic [3:0] {
        SRC_WD, SRC_HT, SRC_X, SRC_Y, SRC_P, SRC_Q,
        SRC_T, SRC_W2, SRC_H2, SRC_A, SRC_B, SRC_C
    } t_src;

    typedef enum logic [2:0] {
        DST_W2, DST_H2, DST_T, DST_A, DST_B, DST_C, DST_D
    } t_dst;

    typedef enum logic [1:0] {
        ACC_LOAD, ACC_ADD, ACC_SUB
    } t_acc;

    typedef enum logic [4:0] {
        OP_W2, OP_H2, OP_PP, OP_A1, OP_QQ, OP_A2,
        OP_XP, OP_B1, OP_YQ, OP_B2,
        OP_XX, OP_C1, OP_YY, OP_C2, OP_WH,
        OP_BB, OP_AC
    } t_op;

    typedef struct packed {
        t_src              src_a;
        t_src              src_b;
        logic [STEP_W-1:0] steps;
        t_dst              dst;
        t_acc              acc;
    } t_op_info;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

    typedef enum logic [3:0] {
        B_IDLE, B_SETUP, B_LOAD, B_MUL, B_ZTEST, B_DECIDE, B_FINAL, B_DONE
    } t_bstate;

    // Microprogram of the quadratic: src_b is fed to the multiplier digit by digit
    function automatic t_op_info op_info(input t_op op);
        t_op_info info;
        info = '{SRC_WD, SRC_WD, STEPS_GEO, DST_W2, ACC_LOAD};
        case (op)
            OP_W2:   info = '{SRC_WD, SRC_WD, STEPS_GEO,  DST_W2, ACC_LOAD};
            OP_H2:   info = '{SRC_HT, SRC_HT, STEPS_GEO,  DST_H2, ACC_LOAD};
            OP_PP:   info = '{SRC_P,  SRC_P,  STEPS_GEO,  DST_T,  ACC_LOAD};
            OP_A1:   info = '{SRC_H2, SRC_T,  STEPS_SQ,   DST_A,  ACC_LOAD};
            OP_QQ:   info = '{SRC_Q,  SRC_Q,  STEPS_GEO,  DST_T,  ACC_LOAD};
            OP_A2:   info = '{SRC_W2, SRC_T,  STEPS_SQ,   DST_A,  ACC_ADD};
            OP_XP:   info = '{SRC_X,  SRC_P,  STEPS_GEO,  DST_T,  ACC_LOAD};
            OP_B1:   info = '{SRC_H2, SRC_T,  STEPS_SQ,   DST_B,  ACC_LOAD};
            OP_YQ:   info = '{SRC_Y,  SRC_Q,  STEPS_GEO,  DST_T,  ACC_LOAD};
            OP_B2:   info = '{SRC_W2, SRC_T,  STEPS_SQ,   DST_B,  ACC_ADD};
            OP_XX:   info = '{SRC_X,  SRC_X,  STEPS_GEO,  DST_T,  ACC_LOAD};
            OP_C1:   info = '{SRC_H2, SRC_T,  STEPS_SQ,   DST_C,  ACC_LOAD};
            OP_YY:   info = '{SRC_Y,  SRC_Y,  STEPS_GEO,  DST_T,  ACC_LOAD};
            OP_C2:   info = '{SRC_W2, SRC_T,  STEPS_SQ,   DST_C,  ACC_ADD};
            OP_WH:   info = '{SRC_H2, SRC_W2, STEPS_SQ,   DST_C,  ACC_SUB};
            OP_BB:   info = '{SRC_B,  SRC_B,  STEPS_WIDE, DST_D,  ACC_LOAD};
            OP_AC:   info = '{SRC_C,  SRC_A,  STEPS_WIDE, DST_D,  ACC_SUB};
            default: info = '{SRC_WD, SRC_WD, STEPS_GEO,  DST_W2, ACC_LOAD};
        endcase
        return info;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/seht_front.sv
`default_nettype none

module seht_front import seht_pkg::*; (
    input  t_cfg                         i_cfg,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_command,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    input  logic                         i_full,
    output logic                         o_push,
    output t_job                         o_job
);

    localparam int OV_W = COORD_BITS + 2;

    logic signed [COORD_BITS-1:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [OV_W-1:0]       bl, br, bt, bb;
    logic                         overlap;

    always_comb begin
        lo_x = (i_bx < i_ax) ? i_bx : i_ax;
        hi_x = (i_bx < i_ax) ? i_ax : i_bx;
        lo_y = (i_by < i_ay) ? i_by : i_ay;
        hi_y = (i_by < i_ay) ? i_ay : i_by;
        bl   = OV_W'(i_cfg.left);
        bt   = OV_W'(i_cfg.top);
        br   = bl + signed'(OV_W'(i_cfg.width));
        bb   = bt + signed'(OV_W'(i_cfg.height));
        // Touching or flat boxes do not count as overlap
        overlap = (lo_x != hi_x) && (lo_y != hi_y)
               && (i_cfg.width != '0) && (i_cfg.height != '0)
               && (OV_W'(lo_x) < br) && (bl < OV_W'(hi_x))
               && (OV_W'(lo_y) < bb) && (bt < OV_W'(hi_y));
    end

    always_comb begin
        o_job.ax = i_ax;
        o_job.ay = i_ay;
        o_job.bx = i_bx;
        o_job.by = i_by;
        if (!i_command) begin
            o_job.kind = KIND_SEG;
        end else if (overlap) begin
            o_job.kind = KIND_RECT;
        end else begin
            o_job.kind = KIND_MISS;
        end
    end

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

endmodule

`default_nettype wire

>>> rtl/core/seht_queue.sv
`default_nettype none

module seht_queue import seht_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_valid
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QPTR_W:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];

endmodule

`default_nettype wire

>>> rtl/core/seht_mul.sv
`default_nettype none

module seht_mul import seht_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MUL_W-1:0]  i_a,
    input  logic [MUL_W-1:0]  i_b,
    input  logic [STEP_W-1:0] i_steps,
    output t_mul_stat         o_stat,
    output logic [PROD_W-1:0] o_prod
);

    logic [MUL_W-1:0]          r_a;
    logic [MUL_W-1:0]          r_b;
    logic [PROD_W-1:0]         r_acc;
    logic [STEP_W-1:0]         r_cnt;
    logic [STEP_W-1:0]         r_shift;
    logic                      r_busy;
    logic                      r_done;

    logic [MUL_W+DIG_W-1:0]    partial;
    logic [MUL_W+DIG_W:0]      sum;
    logic [2*MUL_W+DIG_W:0]    cat;
    logic [PROD_W-1:0]         n_acc;
    logic [STEP_W+DIG_LOG-1:0] align;

    // One multiplier digit per step, low digit first; the accumulator
    // shifts right so the partial product always lands on its top half
    always_comb begin
        partial = r_a * r_b[DIG_W-1:0];
        sum     = {(DIG_W+1)'(0), r_acc[PROD_W-1:MUL_W]} + {1'b0, partial};
        cat     = {sum, r_acc[MUL_W-1:0]};
        n_acc   = cat[PROD_W+DIG_W-1:DIG_W];
        align   = {r_shift, DIG_LOG'(0)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a     <= i_a;
            r_b     <= i_b;
            r_acc   <= '0;
            r_shift <= STEP_W'(MUL_STEPS) - i_steps;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= r_b >> DIG_W;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_prod      = r_acc >> align;

endmodule

`default_nettype wire

>>> rtl/core/seht_back.sv
`default_nettype none

module seht_back import seht_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_job              i_job,
    input  logic              i_job_valid,
    output logic              o_pop,
    output logic              o_mul_start,
    output logic [MUL_W-1:0]  o_mul_a,
    output logic [MUL_W-1:0]  o_mul_b,
    output logic [STEP_W-1:0] o_mul_steps,
    input  t_mul_stat         i_mul_stat,
    input  logic [PROD_W-1:0] i_mul_prod,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_hit
);

    localparam int F_W = C_W + 1;
    localparam int S_W = INSET_BITS + FRAC_BITS;

    t_bstate                  r_state, n_state;
    t_job                     r_job;
    logic [1:0]               r_edge;
    t_op                      r_op;
    logic                     r_res;
    logic                     r_neg;
    logic signed [GEO_W-1:0]  r_wd, r_ht, r_x, r_y, r_p, r_q;
    logic signed [SQ_W-1:0]   r_w2, r_h2;
    logic signed [T_W-1:0]    r_t;
    logic signed [A_W-1:0]    r_a;
    logic signed [B_W-1:0]    r_b;
    logic signed [C_W-1:0]    r_c;
    logic signed [D_W-1:0]    r_d;
    logic                     r_out_valid;
    logic                     r_hit;

    t_op_info                 info;
    logic signed [COORD_BITS-1:0] x1, y1, x2, y2;
    logic [S_W-1:0]           g_s;
    logic signed [GEO_W-1:0]  g_wd, g_ht, g_cx2, g_cy2;
    logic signed [MUL_W:0]    val_a, val_b;
    logic [PROD_W-1:0]        base, wb_res;
    logic                     wb_sub;
    logic signed [F_W-1:0]    f1;
    logic signed [B_W:0]      ab;
    logic                     a_zero, dec_hit, dec_miss, last_seg, out_free;
    logic                     seg_end, seg_hit;

    assign info     = op_info(r_op);
    assign last_seg = (r_job.kind != KIND_RECT) || (r_edge == EDGE_LAST);
    assign out_free = !r_out_valid || !i_out_stall;

    // Endpoints of the current segment or rectangle edge
    always_comb begin
        x1 = r_job.ax; y1 = r_job.ay; x2 = r_job.bx; y2 = r_job.by;
        if (r_job.kind == KIND_RECT) begin
            case (r_edge)
                2'd0: begin x1 = r_job.ax; y1 = r_job.ay; x2 = r_job.bx; y2 = r_job.ay; end
                2'd1: begin x1 = r_job.bx; y1 = r_job.ay; x2 = r_job.bx; y2 = r_job.by; end
                2'd2: begin x1 = r_job.bx; y1 = r_job.by; x2 = r_job.ax; y2 = r_job.by; end
                default: begin
                    x1 = r_job.ax; y1 = r_job.by; x2 = r_job.ax; y2 = r_job.ay;
                end
            endcase
        end
    end

    // Doubled coordinates about the ellipse center
    always_comb begin
        g_s   = {i_cfg.inset, FRAC_BITS'(0)};
        g_wd  = signed'(GEO_W'(i_cfg.width))  - signed'(GEO_W'({g_s, 1'b0}));
        g_ht  = signed'(GEO_W'(i_cfg.height)) - signed'(GEO_W'({g_s, 1'b0}));
        g_cx2 = ((GEO_W'(i_cfg.left) + signed'(GEO_W'(g_s))) <<< 1) + g_wd;
        g_cy2 = ((GEO_W'(i_cfg.top)  + signed'(GEO_W'(g_s))) <<< 1) + g_ht;
    end

    always_comb begin
        case (info.src_a)
            SRC_WD:  val_a = (MUL_W+1)'(r_wd);
            SRC_HT:  val_a = (MUL_W+1)'(r_ht);
            SRC_X:   val_a = (MUL_W+1)'(r_x);
            SRC_Y:   val_a = (MUL_W+1)'(r_y);
            SRC_P:   val_a = (MUL_W+1)'(r_p);
            SRC_Q:   val_a = (MUL_W+1)'(r_q);
            SRC_T:   val_a = (MUL_W+1)'(r_t);
            SRC_W2:  val_a = (MUL_W+1)'(r_w2);
            SRC_H2:  val_a = (MUL_W+1)'(r_h2);
            SRC_A:   val_a = (MUL_W+1)'(r_a);
            SRC_B:   val_a = (MUL_W+1)'(r_b);
            SRC_C:   val_a = (MUL_W+1)'(r_c);
            default: val_a = '0;
        endcase
        case (info.src_b)
            SRC_WD:  val_b = (MUL_W+1)'(r_wd);
            SRC_HT:  val_b = (MUL_W+1)'(r_ht);
            SRC_X:   val_b = (MUL_W+1)'(r_x);
            SRC_Y:   val_b = (MUL_W+1)'(r_y);
            SRC_P:   val_b = (MUL_W+1)'(r_p);
            SRC_Q:   val_b = (MUL_W+1)'(r_q);
            SRC_T:   val_b = (MUL_W+1)'(r_t);
            SRC_W2:  val_b = (MUL_W+1)'(r_w2);
            SRC_H2:  val_b = (MUL_W+1)'(r_h2);
            SRC_A:   val_b = (MUL_W+1)'(r_a);
            SRC_B:   val_b = (MUL_W+1)'(r_b);
            SRC_C:   val_b = (MUL_W+1)'(r_c);
            default: val_b = '0;
        endcase
    end

    assign o_mul_a     = val_a[MUL_W] ? MUL_W'(-val_a) : val_a[MUL_W-1:0];
    assign o_mul_b     = val_b[MUL_W] ? MUL_W'(-val_b) : val_b[MUL_W-1:0];
    assign o_mul_steps = info.steps;

    // Signed accumulate of the unsigned product into the destination
    always_comb begin
        case (info.dst)
            DST_W2:  base = PROD_W'(r_w2);
            DST_H2:  base = PROD_W'(r_h2);
            DST_T:   base = PROD_W'(r_t);
            DST_A:   base = PROD_W'(r_a);
            DST_B:   base = PROD_W'(r_b);
            DST_C:   base = PROD_W'(r_c);
            DST_D:   base = PROD_W'(r_d);
            default: base = '0;
        endcase
        if (info.acc == ACC_LOAD) begin
            base = '0;
        end
        wb_sub = (info.acc == ACC_SUB) ^ r_neg;
        wb_res = base + (wb_sub ? ~i_mul_prod : i_mul_prod) + PROD_W'(wb_sub);
    end

    // Root tests on C = f(0) and F1 = f(1); B is held halved
    always_comb begin
        f1       = F_W'(r_a) + (F_W'(r_b) <<< 1) + F_W'(r_c);
        ab       = (B_W+1)'(r_a) + (B_W+1)'(r_b);
        a_zero   = (r_a == '0);
        dec_hit  = (r_c == '0) || (f1 == '0) || (r_c[C_W-1] != f1[F_W-1]);
        dec_miss = r_c[C_W-1] || (!r_b[B_W-1] && (r_b != '0)) || ab[B_W];
    end

    always_comb begin
        n_state     = r_state;
        o_pop       = 1'b0;
        o_mul_start = 1'b0;
        seg_end     = 1'b0;
        seg_hit     = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_job_valid) begin
                    o_pop   = 1'b1;
                    n_state = (i_job.kind == KIND_MISS) ? B_DONE : B_SETUP;
                end
            end
            B_SETUP: n_state = B_LOAD;
            B_LOAD: begin
                o_mul_start = 1'b1;
                n_state     = B_MUL;
            end
            B_MUL: begin
                if (i_mul_stat.done) begin
                    case (r_op)
                        OP_A2:   n_state = B_ZTEST;
                        OP_WH:   n_state = B_DECIDE;
                        OP_AC:   n_state = B_FINAL;
                        default: n_state = B_LOAD;
                    endcase
                end
            end
            B_ZTEST: begin
                if (a_zero) begin
                    seg_end = 1'b1;
                end else begin
                    n_state = B_LOAD;
                end
            end
            B_DECIDE: begin
                if (dec_hit) begin
                    seg_end = 1'b1;
                    seg_hit = 1'b1;
                end else if (dec_miss) begin
                    seg_end = 1'b1;
                end else begin
                    n_state = B_LOAD;
                end
            end
            B_FINAL: begin
                seg_end = 1'b1;
                seg_hit = !r_d[D_W-1];
            end
            B_DONE: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
        if (seg_end) begin
            n_state = (seg_hit || last_seg) ? B_DONE : B_SETUP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_IDLE && i_job_valid) begin
            r_job  <= i_job;
            r_edge <= 2'd0;
            r_res  <= 1'b0;
            r_op   <= OP_W2;
        end
        if (r_state == B_SETUP) begin
            r_wd <= g_wd;
            r_ht <= g_ht;
            r_x  <= (GEO_W'(x1) <<< 1) - g_cx2;
            r_y  <= (GEO_W'(y1) <<< 1) - g_cy2;
            r_p  <= (GEO_W'(x2) - GEO_W'(x1)) <<< 1;
            r_q  <= (GEO_W'(y2) - GEO_W'(y1)) <<< 1;
        end
        if (r_state == B_LOAD) begin
            r_neg <= val_a[MUL_W] ^ val_b[MUL_W];
        end
        if (r_state == B_MUL && i_mul_stat.done) begin
            case (info.dst)
                DST_W2:  r_w2 <= wb_res[SQ_W-1:0];
                DST_H2:  r_h2 <= wb_res[SQ_W-1:0];
                DST_T:   r_t  <= wb_res[T_W-1:0];
                DST_A:   r_a  <= wb_res[A_W-1:0];
                DST_B:   r_b  <= wb_res[B_W-1:0];
                DST_C:   r_c  <= wb_res[C_W-1:0];
                DST_D:   r_d  <= wb_res[D_W-1:0];
                default: r_d  <= r_d;
            endcase
            if (r_op != OP_AC) begin
                r_op <= t_op'(r_op + 1'b1);
            end
        end
        if (seg_end) begin
            if (seg_hit) begin
                r_res <= 1'b1;
            end else if (!last_seg) begin
                // next rectangle edge reuses W^2 and H^2
                r_edge <= r_edge + 1'b1;
                r_op   <= OP_PP;
            end
        end
        if (r_state == B_DONE && out_free) begin
            r_hit <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;

    a_mul_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_LOAD) |-> !i_mul_stat.busy)
        else $error("multiply started while the multiplier is busy");

    a_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mul_stat.done |-> (r_state == B_MUL))
        else $error("multiplier finished outside the multiply state");

    a_edge_rect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_edge != 2'd0 && r_state != B_IDLE) |-> (r_job.kind == KIND_RECT))
        else $error("edge walk on a job that is not a rectangle");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DONE && r_out_valid && i_out_stall) |=> (r_state == B_DONE))
        else $error("result left while the output register was full");

endmodule

`default_nettype wire

>>> rtl/core/segment_ellipse_hit_test.sv
`default_nettype none

// Channel   Handshake                  Payload
// -------   ------------------------   ------------------------------------
// config    i_cfg_we                   i_cfg_idx, i_cfg_data
// input     i_in_valid / o_in_stall    i_command, i_ax, i_ay, i_bx, i_by
// output    o_out_valid / i_out_stall  o_hit
//
// A segment ends when its quadratic is found degenerate, else when the
// end-point signs decide it, else after the discriminant; later rectangle
// edges skip the W^2 / H^2 products, and a rectangle that misses the box
// needs no products at all. The run time is set by the one shared 112 x 8
// bit multiplier, which retires one 8-bit digit of the multiplier per cycle.
// Reset (synchronous, active low) clears the configuration to zero and
// empties the job queue. Input transactions enter a four-entry queue and are
// taken while the back end computes; a finished result waits in the output
// register while the next job already runs.

module segment_ellipse_hit_test import seht_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0]     i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_command,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_hit
);

    t_cfg              r_cfg;
    logic              push, full, pop, job_valid;
    t_job              front_job, head_job;
    logic              mul_start;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [STEP_W-1:0] mul_steps;
    t_mul_stat         mul_stat;
    logic [PROD_W-1:0] mul_prod;

    // Hold the box registers; writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BOX_LEFT:   r_cfg.left   <= i_cfg_data;
                CFG_BOX_TOP:    r_cfg.top    <= i_cfg_data;
                CFG_BOX_WIDTH:  r_cfg.width  <= i_cfg_data;
                CFG_BOX_HEIGHT: r_cfg.height <= i_cfg_data;
                CFG_INSET:      r_cfg.inset  <= i_cfg_data[INSET_BITS-1:0];
                default:        r_cfg        <= r_cfg;
            endcase
        end
    end

    // Classify: segment, rectangle with real box overlap, or certain miss
    seht_front u_front (
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_command  (i_command),
        .i_ax       (i_ax),
        .i_ay       (i_ay),
        .i_bx       (i_bx),
        .i_by       (i_by),
        .i_full     (full),
        .o_push     (push),
        .o_job      (front_job)
    );

    // Decouple the classifier from the slow evaluator
    seht_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_valid (job_valid)
    );

    // Shared multiplier for every product of the quadratic
    seht_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_steps (mul_steps),
        .o_stat  (mul_stat),
        .o_prod  (mul_prod)
    );

    // Sequence the quadratic over each segment or rectangle edge
    seht_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (head_job),
        .i_job_valid (job_valid),
        .o_pop       (pop),
        .o_mul_start (mul_start),
        .o_mul_a     (mul_a),
        .o_mul_b     (mul_b),
        .o_mul_steps (mul_steps),
        .i_mul_stat  (mul_stat),
        .i_mul_prod  (mul_prod),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_hit       (o_hit)
    );

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import seht_pkg::*;

    localparam int          CLK_HALF     = 2;
    localparam int          RESET_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 4000000;
    localparam int          DRAIN_CYCLES = 700;
    localparam int          HOLD_CYCLES  = 2500;  // long receiver hold-off
    localparam logic        CMD_SEG      = 1'b0;
    localparam logic        CMD_RECT     = 1'b1;
    localparam logic [2:0]  CFG_UNUSED   = 3'd7;  // index past the register list

    // Exact arithmetic for the quadratic; wide enough to never wrap
    typedef logic signed [319:0] t_wide;

    typedef struct {
        logic                         cmd;
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
    } t_shape;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]      i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0]     i_cfg_data = '0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic                         i_command = 1'b0;
    logic signed [COORD_BITS-1:0] i_ax = '0;
    logic signed [COORD_BITS-1:0] i_ay = '0;
    logic signed [COORD_BITS-1:0] i_bx = '0;
    logic signed [COORD_BITS-1:0] i_by = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic                         o_hit;

    // Shadow copy of the configuration registers
    logic signed [COORD_BITS-1:0] box_left   = '0;
    logic signed [COORD_BITS-1:0] box_top    = '0;
    logic        [COORD_BITS-1:0] box_width  = '0;
    logic        [COORD_BITS-1:0] box_height = '0;
    logic        [INSET_BITS-1:0] box_inset  = '0;

    t_shape shapes_to_send[$];
    logic   hits_expected[$];
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    bit     hold_armed = 1'b0;
    int     errors = 0;
    longint cycles = 0;

    segment_ellipse_hit_test u_top (.*);

    always #(CLK_HALF) i_clk = ~i_clk;

    // Run guard: end the run once the cycle count passes CYCLE_LIMIT
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Decide whether a segment meets the ellipse outline. All coordinates are
    // doubled about the centre so that the curve has integer coefficients.
    function automatic bit segment_crosses(input longint x1, input longint y1,
                                           input longint x2, input longint y2);
        longint sh, wd, ht, cx2, cy2;
        t_wide  x, y, p, q, w2, h2, qa, qb, qc, f1, disc;
        sh   = longint'(box_inset) * (1 << FRAC_BITS);
        wd   = longint'(box_width) - 2 * sh;
        ht   = longint'(box_height) - 2 * sh;
        cx2  = 2 * (longint'(box_left) + sh) + wd;
        cy2  = 2 * (longint'(box_top) + sh) + ht;
        x    = 2 * x1 - cx2;
        y    = 2 * y1 - cy2;
        p    = 2 * (x2 - x1);
        q    = 2 * (y2 - y1);
        w2   = t_wide'(wd) * t_wide'(wd);
        h2   = t_wide'(ht) * t_wide'(ht);
        qa   = p * p * h2 + q * q * w2;
        // zero length, or a run along a flat ellipse: never a hit
        if (qa == 0)
            return 1'b0;
        qb   = 2 * (x * p * h2 + y * q * w2);
        qc   = x * x * h2 + y * y * w2 - w2 * h2;
        f1   = qa + qb + qc;
        if (qc == 0 || f1 == 0)
            return 1'b1;
        if ((qc < 0) != (f1 < 0))
            return 1'b1;
        if (qc < 0)
            return 1'b0;
        // both ends outside: the vertex must lie in [0,1] with real roots
        disc = qb * qb - 4 * qa * qc;
        if (disc < 0)
            return 1'b0;
        if (qb > 0)
            return 1'b0;
        return (2 * qa + qb) >= 0;
    endfunction

    // Strict overlap with the unshrunk box; corners are normalized here
    function automatic bit overlaps_box(input longint l, input longint t,
                                        input longint r, input longint b);
        longint bl, bt, br, bb, tmp;
        bl = longint'(box_left);
        bt = longint'(box_top);
        br = bl + longint'(box_width);
        bb = bt + longint'(box_height);
        if (r < l) begin
            tmp = l; l = r; r = tmp;
        end
        if (b < t) begin
            tmp = t; t = b; b = tmp;
        end
        if (l == r || t == b || bl == br || bt == bb)
            return 1'b0;
        if (l >= br || bl >= r || t >= bb || bt >= b)
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic predict_hit(input t_shape s);
        longint ax, ay, bx, by;
        ax = s.ax;
        ay = s.ay;
        bx = s.bx;
        by = s.by;
        if (s.cmd == CMD_SEG)
            return segment_crosses(ax, ay, bx, by);
        // edges top, right, bottom, left exactly as given
        return overlaps_box(ax, ay, bx, by) &&
               (segment_crosses(ax, ay, bx, ay) || segment_crosses(bx, ay, bx, by) ||
                segment_crosses(bx, by, ax, by) || segment_crosses(ax, by, ax, ay));
    endfunction

    // Driver: hold a stalled transaction, otherwise offer the next shape or idle
    always @(posedge i_clk) begin : drive_shapes
        t_shape sent;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                sent = shapes_to_send.pop_front();
                hits_expected.push_back(predict_hit(sent));
            end
            if (i_in_valid && o_in_stall) begin
                // hold payload
            end else if (shapes_to_send.size() != 0 &&
                         $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_command  <= shapes_to_send[0].cmd;
                i_ax       <= shapes_to_send[0].ax;
                i_ay       <= shapes_to_send[0].ay;
                i_bx       <= shapes_to_send[0].bx;
                i_by       <= shapes_to_send[0].by;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each hit against the oldest prediction, drive stall
    always @(posedge i_clk) begin : check_hits
        logic want;
        int   hold_left;
        bit   hold_done;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (hits_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction, hit=%b", o_hit));
                end else begin
                    want = hits_expected.pop_front();
                    if (o_hit !== want)
                        report_mismatch($sformatf("hit=%b, predicted %b", o_hit, want));
                end
            end
            if (hold_armed && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_BOX_LEFT:   box_left   = data;
            CFG_BOX_TOP:    box_top    = data;
            CFG_BOX_WIDTH:  box_width  = data;
            CFG_BOX_HEIGHT: box_height = data;
            CFG_INSET:      box_inset  = data[INSET_BITS-1:0];
            default:        ;
        endcase
    endtask

    task automatic set_box(input longint l, input longint t, input longint w,
                           input longint h, input int ins);
        write_reg(CFG_BOX_LEFT, l[CFG_DATA_BITS-1:0]);
        write_reg(CFG_BOX_TOP, t[CFG_DATA_BITS-1:0]);
        write_reg(CFG_BOX_WIDTH, w[CFG_DATA_BITS-1:0]);
        write_reg(CFG_BOX_HEIGHT, h[CFG_DATA_BITS-1:0]);
        write_reg(CFG_INSET, CFG_DATA_BITS'(ins));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_shape(input logic cmd, input longint ax, input longint ay,
                               input longint bx, input longint by);
        t_shape s;
        s.cmd = cmd;
        s.ax  = ax[COORD_BITS-1:0];
        s.ay  = ay[COORD_BITS-1:0];
        s.bx  = bx[COORD_BITS-1:0];
        s.by  = by[COORD_BITS-1:0];
        shapes_to_send.push_back(s);
    endtask

    // Coordinate in and around the box span; wraps harmlessly at the extremes
    function automatic longint near(input longint lo, input longint span);
        longint reach;
        reach = (span < 64) ? 64 : span;
        return lo - reach / 2 + longint'($urandom_range(32'(2 * reach)));
    endfunction

    task automatic queue_random(input int count);
        longint w, h;
        repeat (count) begin
            w = box_width;
            h = box_height;
            if ($urandom_range(99) < 15) begin
                // noise over the whole coordinate range
                queue_shape($urandom_range(1), $signed($urandom), $signed($urandom),
                            $signed($urandom), $signed($urandom));
            end else if ($urandom_range(1) == 0) begin
                queue_shape(CMD_SEG, near(box_left, w), near(box_top, h),
                            near(box_left, w), near(box_top, h));
            end else begin
                queue_shape(CMD_RECT, near(box_left, w), near(box_top, h),
                            near(box_left, w), near(box_top, h));
            end
        end
    endtask

    // Wait until every queued shape is sent and every predicted hit has been checked
    task automatic drain;
        while (shapes_to_send.size() != 0 || hits_expected.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int phase;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_idle_pct = 35;
        recv_idle_pct = 45;

        // Reset configuration: a zero box never overlaps and every A is zero
        queue_shape(CMD_SEG, -100, -100, 100, 100);
        queue_shape(CMD_RECT, -100, -100, 100, 100);
        drain();

        // Directed: a 100 x 50 unit box with an inset of 2 units
        set_box(0, 0, 1600, 800, 2);
        write_reg(CFG_UNUSED, 24'hFFFFFF);   // ignored write
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        queue_shape(CMD_SEG, -200, 400, 1800, 400);             // through the centre
        queue_shape(CMD_SEG, 700, 400, 900, 400);               // wholly inside
        queue_shape(CMD_SEG, 500, 500, 500, 500);               // zero length
        queue_shape(CMD_SEG, 32, 400, 32, 900);                 // starts on the outline
        queue_shape(CMD_SEG, -200, -200, 1800, -200);           // misses above
        queue_shape(CMD_SEG, -8388608, -8388608, 8388607, 8388607);
        queue_shape(CMD_SEG, 8388607, -8388608, -8388608, 8388607);
        queue_shape(CMD_RECT, -100, -100, 1700, 900);           // encloses the ellipse
        queue_shape(CMD_RECT, 700, 300, 900, 500);              // inside, no crossing
        queue_shape(CMD_RECT, 1700, 900, -100, -100);           // reversed corners
        queue_shape(CMD_RECT, 0, 100, 1600, 100);               // flat rectangle
        queue_shape(CMD_RECT, 1600, 0, 2000, 800);              // touches the right side
        queue_shape(CMD_RECT, 1500, 300, 1700, 500);            // clips the right end
        queue_shape(CMD_RECT, -8388608, -8388608, 8388607, 8388607);
        queue_shape(CMD_RECT, 8388607, 8388607, -8388608, -8388608);
        queue_shape(CMD_RECT, 3000, 3000, 4000, 4000);          // misses the box
        drain();

        // Inset larger than the box: the ellipse mirrors
        set_box(-800, 1200, 100, 60, 255);
        @(negedge i_clk);
        queue_shape(CMD_SEG, -9000, 1230, 8000, 1230);
        queue_shape(CMD_RECT, -820, 1190, -690, 1270);
        queue_shape(CMD_SEG, -750, 1230, -750, 1230);
        drain();

        // Flat box: no rectangle overlaps it
        set_box(0, 0, 0, 800, 0);
        @(negedge i_clk);
        queue_shape(CMD_RECT, -100, -100, 100, 900);
        queue_shape(CMD_SEG, 0, -100, 0, 900);                  // along the flat ellipse
        queue_shape(CMD_SEG, -100, 400, 100, 400);
        drain();

        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_box(-8388608, -8388608, 16777215, 16777215, 0);
                1: set_box(8388607, 8388607, 16777215, 16777215, 255);
                2: set_box(-4096, 2048, 3200, 4800, 10);
                3: set_box(0, 0, 100, 16, 1);
                default: set_box($signed($urandom_range(2000000)) - 1000000,
                                 $signed($urandom_range(2000000)) - 1000000,
                                 $urandom_range(40000), $urandom_range(40000),
                                 $urandom_range(255));
            endcase
            @(negedge i_clk);
            if (phase < 3) begin
                send_idle_pct = 35;
                recv_idle_pct = 45;
            end else if (phase < 6) begin
                send_idle_pct = 45;
                recv_idle_pct = 35;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase == 2)
                hold_armed = 1'b1;   // receiver backs off while items keep coming
            queue_random(75);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && hits_expected.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            if (hits_expected.size() != 0)
                report_mismatch($sformatf("%0d hits never arrived", hits_expected.size()));
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
